@@ sv/seven_segment_display_command_unit_top_macros.svh @@
// Assertion macros for the seven-segment display command unit.
// Used by seven_segment_display_command_unit_top; expects clk and rst_n in scope.
`ifndef SEVEN_SEGMENT_DISPLAY_COMMAND_UNIT_TOP_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_COMMAND_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SSDCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssdcu: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SSDCU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssdcu: next-cycle check failed");

`endif

@@ sv/ssdcu_pkg.sv @@
// Shared types, command codes and the digit segment table of the
// seven-segment display command unit. No dependencies.
`default_nettype none

package ssdcu_pkg;

  typedef enum logic [1:0] {
    OP_SET_DECIMAL = 2'd0,
    OP_SET_RAW     = 2'd1,
    OP_SET_LED     = 2'd2,
    OP_UNKNOWN     = 2'd3
  } op_t;

  // Target codes: display for decimal and raw commands, LED for LED commands.
  localparam logic [1:0] TGT_SHORT = 2'd0;  // three-digit display or right LED
  localparam logic [1:0] TGT_LONG  = 2'd1;  // four-digit display or left LED

  localparam logic [31:0] LIMIT_THREE = 32'd1000;
  localparam logic [31:0] LIMIT_FOUR  = 32'd10000;

  localparam int SEG_W = 7;

  typedef struct packed {
    logic                fits_three;
    logic                fits_four;
    logic [3*SEG_W-1:0]  word_three;
    logic [4*SEG_W-1:0]  word_four;
  } dec_result_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 7'd119;
      4'd1:    code = 7'd65;
      4'd2:    code = 7'd59;
      4'd3:    code = 7'd107;
      4'd4:    code = 7'd77;
      4'd5:    code = 7'd110;
      4'd6:    code = 7'd126;
      4'd7:    code = 7'd67;
      4'd8:    code = 7'd127;
      4'd9:    code = 7'd111;
      default: code = 7'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ sv/seven_segment_display_command_unit_top.sv @@
// Seven-segment display command unit: one command beat in, one result beat
// out. A command beat is registered, decoded against the held display words
// and LED flags, and its result lands in the output register while the state
// updates at the same edge. The unit takes one beat every clock; the only
// stall comes from out_tready, which drops in_tready in the same cycle once
// both the input register and the output register hold a beat.
// Results: out_tuser bit 0 is status (1 rejected), bit 1 is refresh (1 when
// accepted); out_tdata carries the three-digit word low and the four-digit
// word, including the LED bits, high. Both words show the state after the
// command, so a rejected command returns the unchanged words.
// Depends on ssdcu_pkg, ssdcu_decimal and the assertion macro header.
`default_nettype none
`include "seven_segment_display_command_unit_top_macros.svh"

module seven_segment_display_command_unit_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [3:0]  in_tuser,   // [1:0] operation, [3:2] target
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] three_digit_word, [63:32] four_digit_word
  output logic [1:0]       out_tuser   // [0] status, [1] refresh
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [1:0]  s1_op_r;
  logic [1:0]  s1_tgt_r;
  logic [31:0] s1_value_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_status_r;
  logic        out_refresh_r;

  logic [31:0] short_r;
  logic [31:0] short_nxt;
  logic [31:0] long_r;
  logic [31:0] long_nxt;
  logic        right_led_r;
  logic        right_led_nxt;
  logic        left_led_r;
  logic        left_led_nxt;

  logic        out_free;
  logic        advance;
  logic        in_beat;
  logic        ok;
  logic        led_on;
  ssdcu_pkg::op_t         op;
  ssdcu_pkg::dec_result_t dec;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_beat   = in_tvalid && in_tready;

  assign op     = ssdcu_pkg::op_t'(s1_op_r);
  assign led_on = |s1_value_r;

  ssdcu_decimal u_decimal (
    .value  (s1_value_r),
    .result (dec)
  );

  always_comb begin
    ok            = 1'b0;
    short_nxt     = short_r;
    long_nxt      = long_r;
    right_led_nxt = right_led_r;
    left_led_nxt  = left_led_r;
    case (op)
      ssdcu_pkg::OP_SET_DECIMAL: begin
        if (s1_tgt_r == ssdcu_pkg::TGT_SHORT && dec.fits_three) begin
          short_nxt = {11'd0, dec.word_three};
          ok        = 1'b1;
        end else if (s1_tgt_r == ssdcu_pkg::TGT_LONG && dec.fits_four) begin
          long_nxt = {right_led_r, {2{left_led_r}}, 1'b0, dec.word_four};
          ok       = 1'b1;
        end
      end
      ssdcu_pkg::OP_SET_RAW: begin
        if (s1_tgt_r == ssdcu_pkg::TGT_SHORT) begin
          short_nxt = s1_value_r;
          ok        = 1'b1;
        end else if (s1_tgt_r == ssdcu_pkg::TGT_LONG) begin
          long_nxt      = s1_value_r;
          right_led_nxt = s1_value_r[31];
          left_led_nxt  = &s1_value_r[30:29];
          ok            = 1'b1;
        end
      end
      ssdcu_pkg::OP_SET_LED: begin
        if (s1_tgt_r == ssdcu_pkg::TGT_SHORT) begin
          right_led_nxt = led_on;
          long_nxt[31]  = led_on;
          ok            = 1'b1;
        end else if (s1_tgt_r == ssdcu_pkg::TGT_LONG) begin
          left_led_nxt    = led_on;
          long_nxt[30:29] = {2{led_on}};
          ok              = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      short_r     <= '0;
      long_r      <= '0;
      right_led_r <= 1'b0;
      left_led_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        short_r     <= short_nxt;
        long_r      <= long_nxt;
        right_led_r <= right_led_nxt;
        left_led_r  <= left_led_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_op_r    <= in_tuser[1:0];
      s1_tgt_r   <= in_tuser[3:2];
      s1_value_r <= in_tdata;
    end
    if (advance) begin
      out_status_r  <= !ok;
      out_refresh_r <= ok;
    end
  end

  // The words are the state registers; they only move with a new result.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {long_r, short_r};
  assign out_tuser  = {out_refresh_r, out_status_r};

  `SSDCU_ASSERT_NOW(a_status_refresh_excl, out_tvalid, out_tuser[0] != out_tuser[1])
  `SSDCU_ASSERT_NXT(a_reject_keeps_state, advance && !ok, $stable(short_r) && $stable(long_r))
  `SSDCU_ASSERT_NOW(a_right_led_bit, 1'b1, long_r[31] == right_led_r)
  `SSDCU_ASSERT_NOW(a_left_led_bits, left_led_r, long_r[30:29] == 2'b11)

endmodule

`default_nettype wire

@@ sv/ssdcu_decimal.sv @@
// Splits a value below ten thousand into decimal digits and renders the
// three- and four-digit segment words with leading zeros blanked. Uses ssdcu_pkg.
`default_nettype none

module ssdcu_decimal (
  input  wire logic [31:0]            value,
  output ssdcu_pkg::dec_result_t      result
);

  logic [13:0] v;
  logic [26:0] prod_ten;
  logic [26:0] prod_hund;
  logic [27:0] prod_thou;
  logic [10:0] q1;
  logic [7:0]  q2;
  logic [4:0]  q3;
  logic [13:0] rem0;
  logic [10:0] rem1;
  logic [7:0]  rem2;
  logic [3:0]  d0;
  logic [3:0]  d1;
  logic [3:0]  d2;
  logic [3:0]  d3;
  logic        show1;
  logic        show2;
  logic        show3;
  logic [ssdcu_pkg::SEG_W-1:0] seg0;
  logic [ssdcu_pkg::SEG_W-1:0] seg1;
  logic [ssdcu_pkg::SEG_W-1:0] seg2;
  logic [ssdcu_pkg::SEG_W-1:0] seg3;

  // Only values below ten thousand are ever accepted, so 14 bits suffice.
  assign v = value[13:0];

  // Quotients by 10, 100 and 1000 through scaled reciprocals; each is exact
  // for every value below 16384.
  assign prod_ten  = {13'd0, v} * 27'd6554;
  assign prod_hund = {13'd0, v} * 27'd5243;
  assign prod_thou = {14'd0, v} * 28'd8389;
  assign q1 = prod_ten[26:16];
  assign q2 = prod_hund[26:19];
  assign q3 = prod_thou[27:23];

  assign rem0 = v  - ({q1, 3'b000} + {2'b00, q1, 1'b0});
  assign rem1 = q1 - ({q2, 3'b000} + {2'b00, q2, 1'b0});
  assign rem2 = q2 - ({q3, 3'b000} + {2'b00, q3, 1'b0});
  assign d0 = rem0[3:0];
  assign d1 = rem1[3:0];
  assign d2 = rem2[3:0];
  assign d3 = q3[3:0];

  // A higher place is shown only when the value reaches it.
  assign show1 = v >= 14'd10;
  assign show2 = v >= 14'd100;
  assign show3 = v >= 14'd1000;

  assign seg0 = ssdcu_pkg::seg_code(d0);
  assign seg1 = show1 ? ssdcu_pkg::seg_code(d1) : '0;
  assign seg2 = show2 ? ssdcu_pkg::seg_code(d2) : '0;
  assign seg3 = show3 ? ssdcu_pkg::seg_code(d3) : '0;

  // The leftmost place sits in the lowest bits, the ones place in the highest.
  assign result.fits_three = value < ssdcu_pkg::LIMIT_THREE;
  assign result.fits_four  = value < ssdcu_pkg::LIMIT_FOUR;
  assign result.word_three = {seg0, seg1, seg2};
  assign result.word_four  = {seg0, seg1, seg2, seg3};

endmodule

`default_nettype wire

@@ dv/tb_seven_segment_display_command_unit_top.sv @@
// Self-checking testbench for seven_segment_display_command_unit_top.
// Depends on ssdcu_pkg for the command codes and on the top module itself;
// results are checked against a predictor of the display words kept in here.
`timescale 1ns / 100ps

module tb_seven_segment_display_command_unit_top;

  localparam logic [1:0]  TGT_BAD_LO     = 2'd2;
  localparam logic [1:0]  TGT_BAD_HI     = 2'd3;
  localparam int          SHORT_PLACES   = 3;
  localparam int          LONG_PLACES    = 4;
  localparam logic [31:0] SHORT_MAX      = 32'd999;
  localparam logic [31:0] LONG_MAX       = 32'd9999;
  localparam logic [31:0] RIGHT_LED_MASK = 32'h8000_0000;
  localparam logic [31:0] LEFT_LED_MASK  = 32'h6000_0000;
  // Segment patterns for digits 9 down to 0; digit d sits at bits 7d+6..7d.
  localparam logic [69:0] DIGIT_GLYPHS   = {7'd111, 7'd127, 7'd67, 7'd126, 7'd110,
                                            7'd77, 7'd107, 7'd59, 7'd65, 7'd119};
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          DRAIN_LIMIT     = 5000;
  localparam int          SETTLE_CYCLES   = 8;

  typedef struct packed {
    logic        rejected;
    logic        refresh;
    logic [31:0] word3;
    logic [31:0] word4;
  } result_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [3:0]  in_tuser;   // [1:0] operation, [3:2] target
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] three_digit_word, [63:32] four_digit_word
  logic [1:0]  out_tuser;  // [0] status, [1] refresh

  // Predicted display state.
  logic [31:0] disp3_word;
  logic [31:0] disp4_word;
  logic        led_right;
  logic        led_left;

  result_beat_t pending_results[$];
  result_beat_t head_result;
  int unsigned  mismatch_count;
  bit           src_idles;
  bit           sink_idles;
  bit           hold_off_req;

  seven_segment_display_command_unit_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Renders value right-justified; the leftmost place ends in the lowest bits.
  function automatic logic render_digits(input logic [31:0] value, input int places,
                                         output logic [31:0] word);
    int          place_digit[4];
    logic [31:0] rest;
    int          shown;
    rest = value;
    shown = 1;
    word = '0;
    if (value > ((places == SHORT_PLACES) ? SHORT_MAX : LONG_MAX)) return 1'b0;
    for (int i = 0; i < 4; i++) begin
      place_digit[i] = int'(rest % 10);
      rest = rest / 10;
    end
    // Leading zeros are blank, but the ones place always shows.
    for (int i = places - 1; i > 0; i--) begin
      if (place_digit[i] != 0 && shown == 1) shown = i + 1;
    end
    for (int i = 0; i < places; i++) begin
      word = word << 7;
      if (i < shown) word = word | 32'(DIGIT_GLYPHS[7*place_digit[i] +: 7]);
    end
    return 1'b1;
  endfunction

  function automatic result_beat_t predict_display_update(input ssdcu_pkg::op_t op,
                                                          input logic [1:0] target,
                                                          input logic [31:0] value);
    result_beat_t beat;
    logic [31:0]  rendered;
    logic         accepted;
    accepted = 1'b0;
    case (op)
      ssdcu_pkg::OP_SET_DECIMAL: begin
        if (target == ssdcu_pkg::TGT_SHORT) begin
          if (render_digits(value, SHORT_PLACES, rendered)) begin
            disp3_word = rendered;
            accepted = 1'b1;
          end
        end else if (target == ssdcu_pkg::TGT_LONG) begin
          if (render_digits(value, LONG_PLACES, rendered)) begin
            if (led_right) rendered = rendered | RIGHT_LED_MASK;
            if (led_left) rendered = rendered | LEFT_LED_MASK;
            disp4_word = rendered;
            accepted = 1'b1;
          end
        end
      end
      ssdcu_pkg::OP_SET_RAW: begin
        if (target == ssdcu_pkg::TGT_SHORT) begin
          disp3_word = value;
          accepted = 1'b1;
        end else if (target == ssdcu_pkg::TGT_LONG) begin
          disp4_word = value;
          led_right = (value & RIGHT_LED_MASK) != '0;
          // The left LED counts as lit only when both of its bits are set.
          led_left = (value & LEFT_LED_MASK) == LEFT_LED_MASK;
          accepted = 1'b1;
        end
      end
      ssdcu_pkg::OP_SET_LED: begin
        if (target == ssdcu_pkg::TGT_SHORT) begin
          led_right = value != '0;
          disp4_word = led_right ? (disp4_word | RIGHT_LED_MASK)
                                 : (disp4_word & ~RIGHT_LED_MASK);
          accepted = 1'b1;
        end else if (target == ssdcu_pkg::TGT_LONG) begin
          led_left = value != '0;
          disp4_word = led_left ? (disp4_word | LEFT_LED_MASK)
                                : (disp4_word & ~LEFT_LED_MASK);
          accepted = 1'b1;
        end
      end
      default: accepted = 1'b0;
    endcase
    beat.rejected = ~accepted;
    beat.refresh  = accepted;
    beat.word3    = disp3_word;
    beat.word4    = disp4_word;
    return beat;
  endfunction

  // Predict at every accepted command beat.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_results.push_back(predict_display_update(ssdcu_pkg::op_t'(in_tuser[1:0]),
                                                       in_tuser[3:2], in_tdata));
    end
  end

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing expected, actual tuser 0x%0h tdata 0x%016h",
                 $time, out_tuser, out_tdata);
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", 32'(head_result.rejected), 32'(out_tuser[0]));
        check_field("refresh", 32'(head_result.refresh), 32'(out_tuser[1]));
        check_field("three_digit_word", head_result.word3, out_tdata[31:0]);
        check_field("four_digit_word", head_result.word4, out_tdata[63:32]);
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, or one long hold-off when a test asks for it.
  initial begin : result_sink
    int unsigned stall;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        stall = idle_cycles();
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_command(input ssdcu_pkg::op_t op, input logic [1:0] target,
                              input logic [31:0] value);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= {target, op};
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    gap = src_idles ? idle_cycles() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_command();
    ssdcu_pkg::op_t op;
    logic [1:0]     target;
    logic [31:0]    value;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = ssdcu_pkg::OP_SET_DECIMAL;
    else if (pick < 65) op = ssdcu_pkg::OP_SET_RAW;
    else if (pick < 92) op = ssdcu_pkg::OP_SET_LED;
    else                op = ssdcu_pkg::OP_UNKNOWN;
    if ($urandom_range(0, 9) == 0) begin
      target = 2'($urandom_range(TGT_BAD_LO, TGT_BAD_HI));
    end else begin
      target = 2'($urandom_range(ssdcu_pkg::TGT_SHORT, ssdcu_pkg::TGT_LONG));
    end
    pick = $urandom_range(0, 9);
    if (pick < 4)       value = $urandom_range(0, SHORT_MAX);
    else if (pick < 6)  value = $urandom_range(0, LONG_MAX + 1);
    else if (pick == 6) value = ($urandom_range(0, 1) ? SHORT_MAX : LONG_MAX) + $urandom_range(0, 1);
    else                value = $urandom();
    if (op == ssdcu_pkg::OP_SET_LED && $urandom_range(0, 1) == 0) value = '0;
    send_command(op, target, value);
  endtask

  // Stop offering beats and wait for every expected result.
  task automatic drain_results();
    int unsigned waited;
    in_tvalid <= 1'b0;
    waited = 0;
    // The first edge lets the predictor record the last accepted beat.
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      pending_results.delete();
    end
  endtask

  task automatic test_decimal_rendering();
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, 32'd0);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, 32'd7);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, 32'd10);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, 32'd100);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, SHORT_MAX);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, SHORT_MAX + 1);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_SHORT, 32'hFFFF_FFFF);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_LONG, 32'd0);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_LONG, LONG_MAX);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_LONG, LONG_MAX + 1);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_LONG, 32'd1204);
    drain_results();
  endtask

  task automatic test_raw_words_and_leds();
    send_command(ssdcu_pkg::OP_SET_RAW, ssdcu_pkg::TGT_SHORT, 32'hFFFF_FFFF);
    send_command(ssdcu_pkg::OP_SET_RAW, ssdcu_pkg::TGT_LONG, 32'hE000_0000);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_LONG, 32'd42);
    // Only one of the two left LED bits: the left LED reads as off.
    send_command(ssdcu_pkg::OP_SET_RAW, ssdcu_pkg::TGT_LONG, 32'h4000_0000);
    send_command(ssdcu_pkg::OP_SET_LED, ssdcu_pkg::TGT_SHORT, 32'd1);
    send_command(ssdcu_pkg::OP_SET_LED, ssdcu_pkg::TGT_LONG, 32'h8000_0000);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, ssdcu_pkg::TGT_LONG, 32'd8888);
    send_command(ssdcu_pkg::OP_SET_LED, ssdcu_pkg::TGT_LONG, 32'd0);
    send_command(ssdcu_pkg::OP_SET_LED, ssdcu_pkg::TGT_SHORT, 32'd0);
    drain_results();
  endtask

  task automatic test_rejected_commands();
    send_command(ssdcu_pkg::OP_UNKNOWN, ssdcu_pkg::TGT_SHORT, 32'd5);
    send_command(ssdcu_pkg::OP_UNKNOWN, ssdcu_pkg::TGT_LONG, 32'hFFFF_FFFF);
    send_command(ssdcu_pkg::OP_SET_DECIMAL, TGT_BAD_LO, 32'd5);
    send_command(ssdcu_pkg::OP_SET_RAW, TGT_BAD_HI, 32'h1234_5678);
    send_command(ssdcu_pkg::OP_SET_LED, TGT_BAD_LO, 32'd1);
    drain_results();
  endtask

  task automatic test_back_to_back();
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    repeat (150) send_random_command();
    drain_results();
  endtask

  task automatic test_random_commands();
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    repeat (500) send_random_command();
    drain_results();
  endtask

  // The sender keeps offering while results are held back, so input stalls.
  task automatic test_output_hold_off();
    src_idles    = 1'b0;
    sink_idles   = 1'b1;
    hold_off_req = 1'b1;
    repeat (60) send_random_command();
    drain_results();
  endtask

  initial begin
    disp3_word     = '0;
    disp4_word     = '0;
    led_right      = 1'b0;
    led_left       = 1'b0;
    mismatch_count = 0;
    src_idles      = 1'b1;
    sink_idles     = 1'b1;
    hold_off_req   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_decimal_rendering();
    test_raw_words_and_leds();
    test_rejected_commands();
    test_back_to_back();
    test_random_commands();
    test_output_hold_off();

    if (mismatch_count == 0) begin
      $display("seven_segment_display_command_unit_top regression: pass");
    end else begin
      $display("seven_segment_display_command_unit_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("seven_segment_display_command_unit_top regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ssdcu_pkg.sv
sv/ssdcu_decimal.sv
sv/seven_segment_display_command_unit_top.sv
dv/tb_seven_segment_display_command_unit_top.sv
